/* rtl/osdm_pkg.sv */
// Package for the ordered store with remove-highest-price.
// Holds sizes, status codes, controller states and the control/status bundles.
// No dependencies.
package osdm_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;
    localparam int PRICE_W  = 16;
    localparam int TAG_W    = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } osdm_status_t;

    // Request kinds
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } osdm_kind_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } osdm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;      // beat accepted: apply insert or begin search
        logic scan_step;  // compare one entry against the running best
        logic compact;    // close the gap at the best slot, count down
    } osdm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic immediate;  // accepted request finishes in the accept cycle
        logic single;     // exactly one entry held
        logic scan_last;  // current scan index is the last held entry
    } osdm_stat_t;

endpackage

/* rtl/osdm_datapath.sv */
// Datapath: entry storage, running-max search, compaction and result registers.
// Depends on osdm_pkg.
module osdm_datapath
    import osdm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  osdm_cmd_t           cmd,
    output osdm_stat_t          stat,
    input  logic                kind,
    input  logic [PRICE_W-1:0]  price,
    input  logic [TAG_W-1:0]    item_tag,
    output osdm_status_t        status,
    output logic [PRICE_W-1:0]  removed_price,
    output logic [TAG_W-1:0]    removed_tag,
    output logic [OCC_W-1:0]    occupancy
);

    // Entry storage, arrival order, no reset
    logic [PRICE_W-1:0] price_reg [CAPACITY];
    logic [TAG_W-1:0]   tag_reg   [CAPACITY];

    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [IDX_W-1:0]   scan_reg,   scan_next;
    logic [IDX_W-1:0]   best_reg,   best_next;
    logic [PRICE_W-1:0] bprice_reg, bprice_next;
    logic [TAG_W-1:0]   btag_reg,   btag_next;
    osdm_status_t       status_reg, status_next;
    logic [PRICE_W-1:0] rprice_reg, rprice_next;
    logic [TAG_W-1:0]   rtag_reg,   rtag_next;

    logic is_full;
    logic is_empty;
    logic do_write;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign do_write = cmd.start && (kind == KIND_INSERT) && !is_full;

    // Status back to controller
    assign stat.immediate = !((kind == KIND_REMOVE) && !is_empty);
    assign stat.single    = (count_reg == CNT_W'(1));
    assign stat.scan_last = ((CNT_W'(scan_reg) + CNT_W'(1)) == count_reg);

    // Control-side next values
    always_comb
    begin
        count_next  = count_reg;
        scan_next   = scan_reg;
        best_next   = best_reg;
        bprice_next = bprice_reg;
        btag_next   = btag_reg;
        status_next = status_reg;
        rprice_next = rprice_reg;
        rtag_next   = rtag_reg;
        if (cmd.start)
        begin
            rprice_next = '0;
            rtag_next   = '0;
            best_next   = '0;
            scan_next   = IDX_W'(1);
            bprice_next = price_reg[0];
            btag_next   = tag_reg[0];
            if (kind == KIND_INSERT)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
        end
        else if (cmd.scan_step)
        begin
            // strict greater keeps the oldest entry on ties
            if (price_reg[scan_reg] > bprice_reg)
            begin
                best_next   = scan_reg;
                bprice_next = price_reg[scan_reg];
                btag_next   = tag_reg[scan_reg];
            end
            scan_next = scan_reg + IDX_W'(1);
        end
        else if (cmd.compact)
        begin
            status_next = ST_REMOVED;
            rprice_next = bprice_reg;
            rtag_next   = btag_reg;
            count_next  = count_reg - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        bprice_reg <= bprice_next;
        btag_reg   <= btag_next;
        status_reg <= status_next;
        rprice_reg <= rprice_next;
        rtag_reg   <= rtag_next;
    end

    // Entry storage: tail append, or shift down above the removed slot
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            price_reg[count_reg[IDX_W-1:0]] <= price;
            tag_reg[count_reg[IDX_W-1:0]]   <= item_tag;
        end
        else if (cmd.compact)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                if (IDX_W'(i) >= best_reg)
                begin
                    price_reg[i] <= price_reg[i+1];
                    tag_reg[i]   <= tag_reg[i+1];
                end
            end
        end
    end

    assign status        = status_reg;
    assign removed_price = rprice_reg;
    assign removed_tag   = rtag_reg;
    assign occupancy     = OCC_W'(count_reg);

endmodule

/* rtl/osdm_ctrl.sv */
// Controller: sequences accept, max search, compaction and result handoff.
// Depends on osdm_pkg.
module osdm_ctrl
    import osdm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  osdm_stat_t stat,
    output osdm_cmd_t  cmd
);

    osdm_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (stat.immediate)
                        state_next = S_DONE;
                    else if (stat.single)
                        state_next = S_SHIFT;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        cmd.start     = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.compact   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.compact = 1'b1;
            end
            S_DONE:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/ordered_store_delete_max.sv */
// Ordered store with remove-highest-price, stream in / stream out.
// Insert, full or empty results are registered at accept; a remove loads entry 0
// at accept, compares the other held entries one per cycle, then compacts once.
// One request at a time: the next beat is accepted the cycle after the result
// beat is taken. Reset clears the entry count and the controller; stored
// entries are not cleared and are never read before being written.
module ordered_store_delete_max
    import osdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] price, [31:16] item_tag
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] removed_price, [31:16] removed_tag,
                                   // [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    osdm_cmd_t          cmd;
    osdm_stat_t         stat;
    osdm_status_t       status;
    logic [PRICE_W-1:0] removed_price;
    logic [TAG_W-1:0]   removed_tag;
    logic [OCC_W-1:0]   occupancy;

    osdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    osdm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (s_tuser),
        .price         (s_tdata[15:0]),
        .item_tag      (s_tdata[31:16]),
        .status        (status),
        .removed_price (removed_price),
        .removed_tag   (removed_tag),
        .occupancy     (occupancy)
    );

    // Pack result beat
    assign m_tdata = {3'b000, occupancy, removed_tag, removed_price};
    assign m_tuser = status;

endmodule
